/* rtl/core/pidb_pkg.sv */
// ----------------------------------------------------------------------------
// pidb_pkg: shared types for the positional insert/delete buffer
// Operation and status codes, stream field widths, and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package pidb_pkg;

    // Field widths of one transaction
    localparam int POS_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int RES_CNT_W = 7;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    // Stream bus widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_MOVE   = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input transaction
        logic eval;        // check, update counts, set up the shift loop
        logic wr_commit;   // write the fetched byte and step the loop
        logic put_char;    // write the inserted byte at its position
        logic copy_setup;  // start the suffix copy of a move
        logic capture;     // latch the byte of a read
        logic publish;     // load the result into the output register
    } pidb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        func_t func;
        logic  ok;
        logic  move_nop;
        logic  loop_done;
        logic  copy_phase;
        logic  out_busy;
    } pidb_stat_t;

endpackage

/* rtl/core/pidb_ctrl.sv */
// ----------------------------------------------------------------------------
// pidb_ctrl: operation sequencer
// One-hot state machine that walks one transaction through check, shift
// loop, byte write or byte read, and hand-off to the output register.
// ----------------------------------------------------------------------------
module pidb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  pidb_pkg::pidb_stat_t  stat,
    output pidb_pkg::pidb_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EVAL    = 7'b0000010,
        S_LOOP_RD = 7'b0000100,
        S_LOOP_WR = 7'b0001000,
        S_RD_WAIT = 7'b0010000,
        S_RD_CAP  = 7'b0100000,
        S_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new transaction only between operations
    assign s_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (!stat.ok || stat.move_nop) begin
                    state_next = S_FINISH;
                end else if (stat.func == pidb_pkg::FN_READ) begin
                    state_next = S_RD_WAIT;
                end else begin
                    state_next = S_LOOP_RD;
                end
            end
            S_LOOP_RD: begin
                if (!stat.loop_done) begin
                    state_next = S_LOOP_WR;
                end else if (stat.func == pidb_pkg::FN_INSERT) begin
                    cmd.put_char = 1'b1;
                    state_next   = S_FINISH;
                end else if (stat.func == pidb_pkg::FN_MOVE && !stat.copy_phase) begin
                    cmd.copy_setup = 1'b1;
                    state_next     = S_LOOP_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_LOOP_WR: begin
                cmd.wr_commit = 1'b1;
                state_next    = S_LOOP_RD;
            end
            S_RD_WAIT: begin
                state_next = S_RD_CAP;
            end
            S_RD_CAP: begin
                cmd.capture = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_accept_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EVAL))
        else $error("accepted transaction not evaluated next cycle");
`endif

endmodule

/* rtl/core/pidb_datapath.sv */
// ----------------------------------------------------------------------------
// pidb_datapath: bank storage, counts, shift engine and result register
// Two byte memories with one write and one registered read port each, the
// fill counts, the address/length registers of the element shift loop, and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module pidb_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pidb_pkg::pidb_cmd_t                cmd,
    output pidb_pkg::pidb_stat_t               stat,
    input  logic [pidb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [pidb_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pidb_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > pidb_pkg::POS_W) ? CW : pidb_pkg::POS_W) + 1;

    // Captured transaction
    pidb_pkg::func_t                 func_reg;
    logic                            bank_reg;
    logic [pidb_pkg::POS_W-1:0]      pos_reg;
    logic [pidb_pkg::CHAR_W-1:0]     char_reg;

    // Fill counts
    logic [CW-1:0] cnt_a_reg;
    logic [CW-1:0] cnt_b_reg;

    // Shift loop
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [CW-1:0] remain_reg;
    logic [CW-1:0] n_reg;
    logic          up_reg;
    logic          rd_bank_reg;
    logic          wr_bank_reg;
    logic          copy_phase_reg;

    // Memories
    logic [pidb_pkg::CHAR_W-1:0] mem_a [CAPACITY];
    logic [pidb_pkg::CHAR_W-1:0] mem_b [CAPACITY];
    logic [pidb_pkg::CHAR_W-1:0] rdata_a_reg;
    logic [pidb_pkg::CHAR_W-1:0] rdata_b_reg;
    logic [pidb_pkg::CHAR_W-1:0] rdata_sel;
    logic [pidb_pkg::CHAR_W-1:0] wdata;
    logic [AW-1:0]               waddr;
    logic                        we_a;
    logic                        we_b;

    // Results
    logic [pidb_pkg::CHAR_W-1:0]    res_char_reg;
    logic [pidb_pkg::RES_CNT_W-1:0] res_count_reg;
    logic [pidb_pkg::RES_CNT_W-1:0] res_other_reg;
    logic                           res_empty_reg;
    logic                           res_full_reg;
    pidb_pkg::status_t              res_status_reg;
    logic                           m_tvalid_reg;
    logic [pidb_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Evaluation terms
    logic [CW-1:0]     src_cnt;
    logic [CW-1:0]     dst_cnt;
    logic [EW-1:0]     c_ext;
    logic [EW-1:0]     d_ext;
    logic [EW-1:0]     p_ext;
    logic [EW-1:0]     cap_ext;
    logic [EW-1:0]     n_ext;
    pidb_pkg::status_t status_c;
    logic              ok_c;
    logic [CW-1:0]     scnt_new;
    logic [CW-1:0]     dcnt_new;
    logic [AW-1:0]     rd_init;
    logic [AW-1:0]     wr_init;
    logic [CW-1:0]     remain_init;
    logic              up_init;
    logic              rbank_init;
    logic              wbank_init;

    assign src_cnt = bank_reg ? cnt_b_reg : cnt_a_reg;
    assign dst_cnt = bank_reg ? cnt_a_reg : cnt_b_reg;
    assign c_ext   = EW'(src_cnt);
    assign d_ext   = EW'(dst_cnt);
    assign p_ext   = EW'(pos_reg);
    assign cap_ext = EW'(CAPACITY);
    assign n_ext   = c_ext - p_ext;

    // Check position and room
    always_comb begin
        status_c = pidb_pkg::ST_OK;
        case (func_reg)
            pidb_pkg::FN_INSERT: begin
                if (p_ext > c_ext) begin
                    status_c = pidb_pkg::ST_RANGE;
                end else if (c_ext >= cap_ext) begin
                    status_c = pidb_pkg::ST_OVERFLOW;
                end
            end
            pidb_pkg::FN_MOVE: begin
                if (p_ext > c_ext) begin
                    status_c = pidb_pkg::ST_RANGE;
                end else if (d_ext + n_ext > cap_ext) begin
                    status_c = pidb_pkg::ST_OVERFLOW;
                end
            end
            default: begin
                if (p_ext >= c_ext) begin
                    status_c = pidb_pkg::ST_RANGE;
                end
            end
        endcase
    end

    assign ok_c = (status_c == pidb_pkg::ST_OK);

    // Counts after the operation
    always_comb begin
        scnt_new = src_cnt;
        dcnt_new = dst_cnt;
        if (ok_c) begin
            case (func_reg)
                pidb_pkg::FN_INSERT: scnt_new = CW'(c_ext + EW'(1));
                pidb_pkg::FN_REMOVE: scnt_new = CW'(c_ext - EW'(1));
                pidb_pkg::FN_MOVE: begin
                    scnt_new = CW'(p_ext);
                    dcnt_new = CW'(d_ext + n_ext);
                end
                default: begin
                    scnt_new = src_cnt;
                end
            endcase
        end
    end

    // First step of the shift loop
    always_comb begin
        rd_init     = AW'(p_ext);
        wr_init     = AW'(p_ext);
        remain_init = '0;
        up_init     = 1'b1;
        rbank_init  = bank_reg;
        wbank_init  = bank_reg;
        case (func_reg)
            pidb_pkg::FN_INSERT: begin
                rd_init     = AW'(c_ext - EW'(1));
                wr_init     = AW'(c_ext);
                remain_init = CW'(n_ext);
                up_init     = 1'b0;
            end
            pidb_pkg::FN_REMOVE: begin
                rd_init     = AW'(p_ext + EW'(1));
                remain_init = CW'(n_ext - EW'(1));
            end
            pidb_pkg::FN_MOVE: begin
                rd_init     = AW'(d_ext - EW'(1));
                wr_init     = AW'(d_ext - EW'(1) + n_ext);
                remain_init = dst_cnt;
                up_init     = 1'b0;
                rbank_init  = !bank_reg;
                wbank_init  = !bank_reg;
            end
            default: begin
                remain_init = '0;
            end
        endcase
    end

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= pidb_pkg::func_t'(s_tuser[1:0]);
            bank_reg <= s_tuser[2];
            pos_reg  <= s_tdata[5:0];
            char_reg <= s_tdata[13:6];
        end
    end

    // Fill counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end else if (cmd.eval) begin
            if (bank_reg) begin
                cnt_b_reg <= scnt_new;
                cnt_a_reg <= dcnt_new;
            end else begin
                cnt_a_reg <= scnt_new;
                cnt_b_reg <= dcnt_new;
            end
        end
    end

    // Loop control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg     <= '0;
            copy_phase_reg <= 1'b0;
        end else if (cmd.eval) begin
            remain_reg     <= remain_init;
            copy_phase_reg <= 1'b0;
        end else if (cmd.copy_setup) begin
            remain_reg     <= n_reg;
            copy_phase_reg <= 1'b1;
        end else if (cmd.wr_commit) begin
            remain_reg <= remain_reg - CW'(1);
        end
    end

    // Loop addresses and bank selects
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            rd_addr_reg <= rd_init;
            wr_addr_reg <= wr_init;
            up_reg      <= up_init;
            rd_bank_reg <= rbank_init;
            wr_bank_reg <= wbank_init;
            n_reg       <= CW'(n_ext);
        end else if (cmd.copy_setup) begin
            rd_addr_reg <= AW'(p_ext);
            wr_addr_reg <= '0;
            up_reg      <= 1'b1;
            rd_bank_reg <= bank_reg;
            wr_bank_reg <= !bank_reg;
        end else if (cmd.wr_commit) begin
            if (up_reg) begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
                wr_addr_reg <= wr_addr_reg + AW'(1);
            end else begin
                rd_addr_reg <= rd_addr_reg - AW'(1);
                wr_addr_reg <= wr_addr_reg - AW'(1);
            end
        end
    end

    // Write port select
    assign rdata_sel = rd_bank_reg ? rdata_b_reg : rdata_a_reg;
    assign wdata     = cmd.put_char ? char_reg : rdata_sel;
    assign waddr     = cmd.put_char ? AW'(p_ext) : wr_addr_reg;
    assign we_a      = (cmd.wr_commit && !wr_bank_reg) || (cmd.put_char && !bank_reg);
    assign we_b      = (cmd.wr_commit && wr_bank_reg) || (cmd.put_char && bank_reg);

    // Bank A memory
    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[waddr] <= wdata;
        end
        rdata_a_reg <= mem_a[rd_addr_reg];
    end

    // Bank B memory
    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[waddr] <= wdata;
        end
        rdata_b_reg <= mem_b[rd_addr_reg];
    end

    // Result fields
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            res_char_reg   <= '0;
            res_count_reg  <= pidb_pkg::RES_CNT_W'(scnt_new);
            res_other_reg  <= pidb_pkg::RES_CNT_W'(dcnt_new);
            res_empty_reg  <= (scnt_new == '0);
            res_full_reg   <= (scnt_new == CW'(CAPACITY));
            res_status_reg <= status_c;
        end else if (cmd.capture) begin
            res_char_reg <= rdata_sel;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_tdata_reg <= pidb_pkg::M_TDATA_W'({res_status_reg, res_full_reg, res_empty_reg,
                                                 res_other_reg, res_count_reg, res_char_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status to the controller
    assign stat.func       = func_reg;
    assign stat.ok         = ok_c;
    assign stat.move_nop   = (func_reg == pidb_pkg::FN_MOVE) && (n_ext == '0);
    assign stat.loop_done  = (remain_reg == '0);
    assign stat.copy_phase = copy_phase_reg;
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CW'(CAPACITY)) && (cnt_b_reg <= CW'(CAPACITY)))
        else $error("bank fill count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.eval && func_reg == pidb_pkg::FN_INSERT && ok_c) |=>
        ((EW'(cnt_a_reg) + EW'(cnt_b_reg)) ==
         ($past(EW'(cnt_a_reg) + EW'(cnt_b_reg)) + EW'(1))))
        else $error("successful insert did not add one byte");

    a_move_keeps_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.eval && func_reg == pidb_pkg::FN_MOVE) |=>
        ((EW'(cnt_a_reg) + EW'(cnt_b_reg)) == $past(EW'(cnt_a_reg) + EW'(cnt_b_reg))))
        else $error("move changed the total byte count");
`endif

endmodule

/* rtl/core/positional_insert_delete_buffer.sv */
// ----------------------------------------------------------------------------
// positional_insert_delete_buffer: two-bank positional edit buffer
// Top level joining the operation sequencer and the storage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries one operation (insert, remove, move the
//   suffix of a bank to the front of the other bank, read one byte) and
//   returns exactly one result transaction with the byte read, both fill
//   counts, the empty and full flags and a status code.
//   A read waits on the registered memory read, then captures the byte;
//   remove, insert and move run the shift loop; a rejected operation or
//   an empty move skips the loop and goes straight to the result.
//   The shift loop moves one byte per read/write state pair through the
//   single registered read port of each bank; that loop sets the rate.
//   s_tready rises in the same cycle as m_tvalid, so the next operation
//   can be accepted while a result still waits on m_tready.
//   If the receiver stalls, the result holds in the output register and a
//   following operation waits at its final step until that slot frees.
//   After reset both counts are zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_insert_delete_buffer #(
    parameter int CAPACITY = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [5:0] position, [13:6] char_in
    input  logic [pidb_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] func, [2] bank
    input  logic [pidb_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] char_out, [14:8] count, [21:15] other_count, [22] empty_res,
    // [23] full_res, [25:24] status
    output logic [pidb_pkg::M_TDATA_W-1:0]     m_tdata
);

    pidb_pkg::pidb_cmd_t  cmd;
    pidb_pkg::pidb_stat_t stat;

    pidb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
